// File: rtl/sha256_pkg.sv
// Shared types, constants and round functions of the SHA-256 hasher.
`timescale 1ns / 1ps

package sha256_pkg;

	localparam int BLOCK_WORDS  = 16;
	localparam int DIGEST_WORDS = 8;
	localparam int ROUNDS       = 64;
	localparam int FIFO_DEPTH   = 4;
	localparam int FIFO_AW      = 2;

	localparam logic [31:0] PAD_FIRST = 32'h8000_0000;

	typedef enum logic [1:0] {
		CMD_ABSORB,
		CMD_FIN_OK,
		CMD_FIN_ERR
	} cmd_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] word;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_OUT
	} state_t;

	localparam logic [31:0] ROUND_K [ROUNDS] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	localparam logic [31:0] HASH_IV [DIGEST_WORDS] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

// File: rtl/sha256_front.sv
// Front end: accepts items, tracks the block fill and classifies finishes.
`timescale 1ns / 1ps

module sha256_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                action,
	input  logic [31:0]         word,
	output logic                push,
	output sha256_pkg::entry_t  push_entry,
	input  logic                fifo_full
);

	logic [3:0] word_index_q;
	logic       accept;

	assign in_stall = fifo_full;
	assign accept   = in_valid && !in_stall;
	assign push     = accept;

	always_comb begin
		push_entry.word = word;
		if (!action) begin
			push_entry.cmd = sha256_pkg::CMD_ABSORB;
		end else if (word_index_q == 4'd0) begin
			push_entry.cmd = sha256_pkg::CMD_FIN_OK;
		end else begin
			push_entry.cmd = sha256_pkg::CMD_FIN_ERR;
		end
	end

	// The index wraps to zero on the sixteenth word, and any finish restarts the message.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_index_q <= 4'd0;
		end else if (accept) begin
			if (action) begin
				word_index_q <= 4'd0;
			end else begin
				word_index_q <= word_index_q + 4'd1;
			end
		end
	end

endmodule

// File: rtl/sha256_fifo.sv
// Short queue of classified items between the front end and the hash core.
`timescale 1ns / 1ps

module sha256_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  sha256_pkg::entry_t  push_entry,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output sha256_pkg::entry_t  head_entry
);

	sha256_pkg::entry_t                   mem_q [sha256_pkg::FIFO_DEPTH];
	logic [sha256_pkg::FIFO_AW-1:0]       wr_ptr_q;
	logic [sha256_pkg::FIFO_AW-1:0]       rd_ptr_q;
	logic [sha256_pkg::FIFO_AW:0]         count_q;
	logic                                 do_push;
	logic                                 do_pop;

	assign full       = (count_q == (sha256_pkg::FIFO_AW+1)'(sha256_pkg::FIFO_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + (sha256_pkg::FIFO_AW)'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + (sha256_pkg::FIFO_AW)'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (sha256_pkg::FIFO_AW+1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (sha256_pkg::FIFO_AW+1)'(1);
			end
		end
	end

endmodule

// File: rtl/sha256_core.sv
// Back end: collects blocks, runs the compression rounds and sends the digest.
`timescale 1ns / 1ps

module sha256_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_valid,
	input  sha256_pkg::entry_t  head_entry,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [31:0]         digest_word,
	output logic                last,
	output logic                error
);

	localparam logic [4:0] BUF_FULL   = 5'(sha256_pkg::BLOCK_WORDS);
	localparam logic [5:0] LAST_ROUND = 6'(sha256_pkg::ROUNDS - 1);
	localparam logic [2:0] LAST_WORD  = 3'(sha256_pkg::DIGEST_WORDS - 1);

	sha256_pkg::state_t state_q, state_next;

	logic [31:0] buf_q  [sha256_pkg::BLOCK_WORDS];
	logic [4:0]  buf_cnt_q;
	logic [31:0] w_q    [sha256_pkg::BLOCK_WORDS];
	logic [31:0] v_q    [sha256_pkg::DIGEST_WORDS];
	logic [31:0] hash_q [sha256_pkg::DIGEST_WORDS];
	logic [54:0] block_count_q;
	logic [5:0]  rnd_q;
	logic [2:0]  k_q;
	logic        fin_q;
	logic        err_q;

	logic        head_absorb;
	logic        head_fin;
	logic        start_blk;
	logic        take_fin;
	logic        out_load;
	logic        out_done;

	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] choose;
	logic [31:0] major;
	logic [31:0] w_new;

	logic        out_valid_q;
	logic [31:0] digest_q;
	logic        last_q;
	logic        error_q;

	assign head_absorb = head_valid && (head_entry.cmd == sha256_pkg::CMD_ABSORB);
	assign head_fin    = head_valid && (head_entry.cmd != sha256_pkg::CMD_ABSORB);

	// Control decode for the current state.
	always_comb begin
		start_blk = 1'b0;
		take_fin  = 1'b0;
		out_load  = 1'b0;
		out_done  = 1'b0;
		case (state_q)
			sha256_pkg::ST_IDLE: begin
				// A full buffered block goes first; a finish only sees an idle core.
				start_blk = (buf_cnt_q == BUF_FULL);
				take_fin  = (buf_cnt_q != BUF_FULL) && head_fin;
			end
			sha256_pkg::ST_OUT: begin
				out_load = !out_valid_q || !out_stall;
				out_done = out_load && (err_q || (k_q == LAST_WORD));
			end
			default: begin
			end
		endcase
		pop = (head_absorb && (buf_cnt_q != BUF_FULL)) || take_fin;
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			sha256_pkg::ST_IDLE: begin
				if (start_blk) begin
					state_next = sha256_pkg::ST_ROUND;
				end else if (take_fin) begin
					if (head_entry.cmd == sha256_pkg::CMD_FIN_OK) begin
						state_next = sha256_pkg::ST_ROUND;
					end else begin
						state_next = sha256_pkg::ST_OUT;
					end
				end
			end
			sha256_pkg::ST_ROUND: begin
				if (rnd_q == LAST_ROUND) begin
					state_next = sha256_pkg::ST_ADD;
				end
			end
			sha256_pkg::ST_ADD: begin
				state_next = fin_q ? sha256_pkg::ST_OUT : sha256_pkg::ST_IDLE;
			end
			sha256_pkg::ST_OUT: begin
				if (out_done) begin
					state_next = sha256_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = sha256_pkg::ST_IDLE;
			end
		endcase
	end

	// One compression round and one schedule word per cycle.
	always_comb begin
		choose = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		major  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1     = v_q[7] + sha256_pkg::big_sigma1(v_q[4]) + choose
		         + sha256_pkg::ROUND_K[rnd_q] + w_q[0];
		t2     = sha256_pkg::big_sigma0(v_q[0]) + major;
		w_new  = w_q[0] + sha256_pkg::small_sigma0(w_q[1]) + w_q[9]
		         + sha256_pkg::small_sigma1(w_q[14]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sha256_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk) begin
		if (head_absorb && pop) begin
			buf_q[buf_cnt_q[3:0]] <= head_entry.word;
		end
	end

	// Schedule window and working variables.
	always_ff @(posedge clk) begin
		if (start_blk) begin
			for (int i = 0; i < sha256_pkg::BLOCK_WORDS; i++) begin
				w_q[i] <= buf_q[i];
			end
		end else if (take_fin) begin
			for (int i = 0; i < sha256_pkg::BLOCK_WORDS; i++) begin
				w_q[i] <= '0;
			end
			w_q[0]  <= sha256_pkg::PAD_FIRST;
			w_q[14] <= block_count_q[54:23];
			w_q[15] <= {block_count_q[22:0], 9'b0};
		end else if (state_q == sha256_pkg::ST_ROUND) begin
			for (int i = 0; i < sha256_pkg::BLOCK_WORDS - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[sha256_pkg::BLOCK_WORDS-1] <= w_new;
		end

		if (start_blk || take_fin) begin
			for (int i = 0; i < sha256_pkg::DIGEST_WORDS; i++) begin
				v_q[i] <= hash_q[i];
			end
		end else if (state_q == sha256_pkg::ST_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_cnt_q     <= '0;
			block_count_q <= '0;
			rnd_q         <= '0;
			k_q           <= '0;
			fin_q         <= 1'b0;
			err_q         <= 1'b0;
			for (int i = 0; i < sha256_pkg::DIGEST_WORDS; i++) begin
				hash_q[i] <= sha256_pkg::HASH_IV[i];
			end
		end else begin
			if (start_blk) begin
				buf_cnt_q <= '0;
			end else if (take_fin) begin
				// A partial block is thrown away with the rest of the message.
				buf_cnt_q <= '0;
			end else if (head_absorb && pop) begin
				buf_cnt_q <= buf_cnt_q + 5'd1;
			end

			if (start_blk || take_fin) begin
				rnd_q <= '0;
				k_q   <= '0;
				fin_q <= take_fin;
				err_q <= take_fin && (head_entry.cmd == sha256_pkg::CMD_FIN_ERR);
			end else if (state_q == sha256_pkg::ST_ROUND) begin
				rnd_q <= rnd_q + 6'd1;
			end else if (out_load && !out_done) begin
				k_q <= k_q + 3'd1;
			end

			if (state_q == sha256_pkg::ST_ADD) begin
				for (int i = 0; i < sha256_pkg::DIGEST_WORDS; i++) begin
					hash_q[i] <= hash_q[i] + v_q[i];
				end
				if (!fin_q) begin
					block_count_q <= block_count_q + 55'd1;
				end
			end else if (out_done) begin
				block_count_q <= '0;
				for (int i = 0; i < sha256_pkg::DIGEST_WORDS; i++) begin
					hash_q[i] <= sha256_pkg::HASH_IV[i];
				end
			end
		end
	end

	// Output register: a result waits here while the next one is prepared.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			digest_q <= err_q ? 32'd0 : hash_q[k_q];
			last_q   <= err_q || (k_q == LAST_WORD);
			error_q  <= err_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign digest_word = digest_q;
	assign last        = last_q;
	assign error       = error_q;

endmodule

// File: rtl/sha256_hasher.sv
// Top level of the SHA-256 hasher: front end, item queue and hash core.
//
// Input channel (in_valid / in_stall): action 0 absorbs one big-endian
// message word; action 1 finishes the message. Output channel (out_valid /
// out_stall) returns digest_word h0..h7 with last set on h7, or a single
// item with error and last set and a zero word when the finish found a
// partly filled block.
// Words pass through a four-entry queue into a 16-word block buffer, one
// word a cycle while the buffer has room. A full block passes through the
// core as a load, 64 rounds and a hash update, all on the single round
// unit, which limits the sustained rate; the next block fills the buffer
// meanwhile.
// A finish waits for the core to go idle, then runs the padding block
// through the core and sends the eight digest words; an error item goes
// from idle straight to the output state. After the digest the hash
// words return to the initial values and the block count to zero.
// Reset (arst_n low) clears the queue, the counters and the output valid
// flag and loads the initial hash values. When out_stall is high the pending
// item holds; the queue then fills and in_stall rises.
`timescale 1ns / 1ps

module sha256_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [31:0] word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic        last,
	output logic        error
);

	logic               push;
	sha256_pkg::entry_t push_entry;
	logic               fifo_full;
	logic               pop;
	logic               head_valid;
	sha256_pkg::entry_t head_entry;

	sha256_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.word       (word),
		.push       (push),
		.push_entry (push_entry),
		.fifo_full  (fifo_full)
	);

	sha256_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (fifo_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	sha256_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_entry  (head_entry),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.digest_word (digest_word),
		.last        (last),
		.error       (error)
	);

endmodule

// File: rtl/sha256_chk.sv
// Port-level checks of the SHA-256 hasher, bound to the top level.
`timescale 1ns / 1ps

module sha256_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] digest_word,
	input logic        last,
	input logic        error
);

	// An error item closes its run and carries no digest.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && error) |-> (last && (digest_word == 32'd0)))
		else $error("error item without last or with nonzero word");

	// Within a digest run the next word is ready right after one is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last) |=> (out_valid && !error))
		else $error("digest run broken or error inside a run");

	// A taken item without last never carries the error flag, so an error item is always last.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !last) |-> !error)
		else $error("error flag on a non-final item");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(digest_word)
		&& $stable(last) && $stable(error)))
		else $error("stalled output item changed");

endmodule

bind sha256_hasher sha256_chk u_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.digest_word (digest_word),
	.last        (last),
	.error       (error)
);
